@@ rtl/core/uart_16550_register_block_assert.svh @@
// Assertion macros for the UART register block.
// Used by rtl/core modules through a plain include; no other dependencies.
`ifndef UART_16550_REGISTER_BLOCK_ASSERT_SVH
`define UART_16550_REGISTER_BLOCK_ASSERT_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define UART_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
// When cond holds, expr must hold in the same cycle.
`define UART_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
		else $error("implication failed");
`else
`define UART_ASSERT(label, clk, rst_n, prop)
`define UART_ASSERT_IMPL(label, clk, rst_n, cond, expr)
`endif
`endif

@@ rtl/core/uart16550_pkg.sv @@
// Constants for the 16550-style UART register block.
// No dependencies; imported by uart_16550_register_block.
`default_nettype none
package uart16550_pkg;

	localparam logic [1:0] OP_READ   = 2'd0;
	localparam logic [1:0] OP_WRITE  = 2'd1;
	localparam logic [1:0] OP_RX     = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam logic [2:0] ADDR_RBR = 3'd0;
	localparam logic [2:0] ADDR_IER = 3'd1;
	localparam logic [2:0] ADDR_IIR = 3'd2;
	localparam logic [2:0] ADDR_LCR = 3'd3;
	localparam logic [2:0] ADDR_MCR = 3'd4;
	localparam logic [2:0] ADDR_LSR = 3'd5;
	localparam logic [2:0] ADDR_MSR = 3'd6;
	localparam logic [2:0] ADDR_SCR = 3'd7;

	localparam logic [2:0] IIR_NONE = 3'd1;
	localparam logic [2:0] IIR_THRE = 3'd2;
	localparam logic [2:0] IIR_RDA  = 3'd4;
	localparam logic [1:0] IIR_SEL_THRE = 2'd1;
	localparam logic [1:0] IIR_SEL_RDA  = 2'd2;

	localparam logic [15:0] DIV_RESET = 16'h00a0;
	localparam logic [3:0]  IER_MASK  = 4'hf;
	localparam logic [7:0]  LSR_BASE  = 8'h60;
	localparam logic [7:0]  MSR_VALUE = 8'h80;
	localparam logic [7:0]  LCR_BASE  = 8'h03;
	localparam logic [7:0]  LCR_DIV_ACCESS = 8'h80;

endpackage
`default_nettype wire

@@ rtl/core/uart_16550_register_block.sv @@
// 16550-style UART register file: bus reads/writes and received bytes, one result per item.
// Depends on uart16550_pkg and uart_16550_register_block_assert.svh.
`default_nettype none
`include "uart_16550_register_block_assert.svh"
// One item is accepted every cycle while in_stall is low. Each item is captured in an input
// register, the register file is updated and the result is computed when the item leaves it,
// and the result sits in an output register. in_stall is raised only while the output
// register holds an untaken result and the input register is also full. Read side effects
// (RBR and IIR interrupt acknowledge) apply when the item passes from the input register to
// the output register, in item order.
module uart_16550_register_block
	import uart16550_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] op,
	input  wire logic [2:0] bus_addr,
	input  wire logic [7:0] bus_data,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      read_data,
	output logic            tx_valid,
	output logic [7:0]      tx_byte,
	output logic            rx_accepted,
	output logic            irq_out
);

	logic       valid_s1;
	logic [1:0] op_s1;
	logic [2:0] addr_s1;
	logic [7:0] data_s1;

	logic       out_valid_q;
	logic [7:0] read_data_q;
	logic       tx_valid_q;
	logic [7:0] tx_byte_q;
	logic       rx_accepted_q;
	logic       irq_q;

	logic [7:0]  rx_holding_q;
	logic [15:0] divisor_q;
	logic [3:0]  int_enable_q;
	logic        dlab_q;
	logic [2:0]  int_ident_q;
	logic        rx_ready_q;
	logic        tx_pending_q;

	logic        advance;
	logic        fire;
	logic        pending;
	logic        ack;
	logic [7:0]  rd;
	logic        txv;
	logic        acc;
	logic [7:0]  rx_holding_d;
	logic [15:0] divisor_d;
	logic [3:0]  int_enable_d;
	logic        dlab_d;
	logic [2:0]  ident_mid;
	logic [2:0]  ident_d;
	logic        rx_ready_d;
	logic        tx_mid;
	logic        tx_d;

	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;

	assign pending = !int_ident_q[0];

	always_comb begin
		unique case (addr_s1)
			ADDR_RBR: rd = dlab_q ? divisor_q[7:0] : rx_holding_q;
			ADDR_IER: rd = dlab_q ? divisor_q[15:8] : {4'd0, int_enable_q};
			ADDR_IIR: rd = {5'd0, int_ident_q};
			ADDR_LCR: rd = dlab_q ? (LCR_BASE | LCR_DIV_ACCESS) : LCR_BASE;
			ADDR_LSR: rd = LSR_BASE | {7'd0, rx_ready_q};
			ADDR_MSR: rd = MSR_VALUE;
			default:  rd = 8'd0;
		endcase
	end

	always_comb begin
		rx_holding_d = rx_holding_q;
		divisor_d    = divisor_q;
		int_enable_d = int_enable_q;
		dlab_d       = dlab_q;
		ident_mid    = int_ident_q;
		rx_ready_d   = rx_ready_q;
		tx_mid       = tx_pending_q;
		txv          = 1'b0;
		acc          = 1'b0;
		ack          = 1'b0;
		unique case (op_s1)
			OP_READ: begin
				ack = pending && !dlab_q &&
					((int_ident_q[2:1] == IIR_SEL_RDA && addr_s1 == ADDR_RBR) ||
					 (int_ident_q[2:1] == IIR_SEL_THRE && addr_s1 == ADDR_IIR));
				if (ack) begin
					rx_ready_d   = 1'b0;
					ident_mid[0] = 1'b1;
				end
			end
			OP_WRITE: begin
				if (pending && int_ident_q[2:1] == IIR_SEL_THRE &&
					addr_s1 == ADDR_RBR && !dlab_q)
					ident_mid[0] = 1'b1;
				if (addr_s1 == ADDR_RBR) begin
					if (dlab_q)
						divisor_d[7:0] = data_s1;
					else begin
						txv    = 1'b1;
						tx_mid = 1'b1;
					end
				end else if (addr_s1 == ADDR_IER) begin
					if (dlab_q)
						divisor_d[15:8] = data_s1;
					else
						int_enable_d = data_s1[3:0] & IER_MASK;
				end else if (addr_s1 == ADDR_LCR) begin
					dlab_d = data_s1[7];
				end
			end
			OP_RX: begin
				if (!pending) begin
					rx_holding_d = data_s1;
					rx_ready_d   = 1'b1;
					acc          = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		ident_d = ident_mid;
		tx_d    = tx_mid;
		if (ident_mid[0] && op_s1 != OP_UNUSED) begin
			priority if (rx_ready_d && int_enable_d[0]) begin
				ident_d = IIR_RDA;
			end else if (tx_mid && int_enable_d[1]) begin
				tx_d    = 1'b0;
				ident_d = IIR_THRE;
			end else begin
				ident_d = ident_mid;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1   <= op;
			addr_s1 <= bus_addr;
			data_s1 <= bus_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			rx_holding_q <= 8'd0;
			divisor_q    <= DIV_RESET;
			int_enable_q <= 4'd0;
			dlab_q       <= 1'b0;
			int_ident_q  <= IIR_NONE;
			rx_ready_q   <= 1'b0;
			tx_pending_q <= 1'b0;
		end else begin
			if (advance)
				out_valid_q <= valid_s1;
			if (fire) begin
				rx_holding_q <= rx_holding_d;
				divisor_q    <= divisor_d;
				int_enable_q <= int_enable_d;
				dlab_q       <= dlab_d;
				int_ident_q  <= ident_d;
				rx_ready_q   <= rx_ready_d;
				tx_pending_q <= tx_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			read_data_q   <= (op_s1 == OP_READ) ? rd : 8'd0;
			tx_valid_q    <= txv;
			tx_byte_q     <= txv ? data_s1 : 8'd0;
			rx_accepted_q <= acc;
			irq_q         <= !ident_d[0];
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = read_data_q;
	assign tx_valid    = tx_valid_q;
	assign tx_byte     = tx_byte_q;
	assign rx_accepted = rx_accepted_q;
	assign irq_out     = irq_q;

	`UART_ASSERT(a_ident_legal, clk, arst_n,
		int_ident_q[0] || int_ident_q == IIR_THRE || int_ident_q == IIR_RDA)
	`UART_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall,
		valid_s1 && out_valid_q && out_stall)
	`UART_ASSERT_IMPL(a_irq_tracks_ident, clk, arst_n, out_valid_q,
		irq_q == !int_ident_q[0])
	`UART_ASSERT_IMPL(a_tx_exclusive, clk, arst_n, out_valid_q && tx_valid_q,
		read_data_q == 8'd0 && !rx_accepted_q)

endmodule
`default_nettype wire
